[hw/rtl/sgtt_pkg.sv]
// Shared types and constants for the state gated periodic task timer.
// Used by sgtt_cell, the top level and the testbench; depends on nothing else.
`timescale 1ns / 1ps

package sgtt_pkg;

	localparam int SLOT_W       = 4;
	localparam int KEY_W        = 16;
	localparam int MODE_IN_W    = 3;
	localparam int ST_W         = 2;
	localparam int RESULT_LIMIT = 16;
	localparam int RES_CNT_W    = 5;

	// Opcodes of the input transaction.
	typedef enum logic [2:0] {
		OP_ADD_MODE = 3'd0,
		OP_SWITCH   = 3'd1,
		OP_QUERY    = 3'd2,
		OP_REGISTER = 3'd3,
		OP_TICK     = 3'd4,
		OP_DRAIN    = 3'd5,
		OP_RSVD6    = 3'd6,
		OP_RSVD7    = 3'd7
	} sgtt_op_t;

	// Result status codes.
	localparam logic [ST_W-1:0] ST_OK    = 2'd0;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
	localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

	// Kind of sweep the token is running along the chain.
	localparam logic [1:0] SW_NONE   = 2'd0;
	localparam logic [1:0] SW_SEARCH = 2'd1;
	localparam logic [1:0] SW_TICK   = 2'd2;
	localparam logic [1:0] SW_DRAIN  = 2'd3;

	// Strobes broadcast from the sequencer to every cell.
	typedef struct packed {
		logic       step;
		logic       clear;
		logic [1:0] sweep;
		logic       take;
		logic       wr_new;
		logic       set_mask;
		logic       clr_mask;
	} sgtt_ctl_t;

	// Status returned by each cell.
	typedef struct packed {
		logic valid;
		logic act;
		logic pend;
		logic match;
	} sgtt_stat_t;

	// One result transaction.
	typedef struct packed {
		logic [ST_W-1:0]      status;
		logic [SLOT_W-1:0]    slot;
		logic [KEY_W-1:0]     key;
		logic [MODE_IN_W-1:0] prev;
		logic                 changed;
		logic                 match;
		logic                 last;
	} sgtt_res_t;

endpackage

[hw/rtl/state_gated_periodic_task_timer_unit.sv]
// Top level of the state gated periodic task timer: command sequencer,
// mode state, output register and the chain of sgtt_cell task entries.
// Depends on sgtt_pkg and sgtt_cell.
`timescale 1ns / 1ps

// Channel  Handshake               Payload
// -------  ----------------------  ------------------------------------------
// in       in_valid / in_ready     opcode, mode_index, task_key, period_ticks
// out      out_valid / out_ready   status, slot, slot_key, previous_mode,
//                                  mode_changed, mode_match, last
//
// Add, switch, query, unknown opcodes and a register against a full table
// put their result in the result register, which moves to the output register
// once that is free. Tick and drain walk a token down the cell chain, one task
// entry per cycle unless a drain stalls; a register walks it to the first
// matching entry or past the registered tasks, then writes the entry. A drain
// stalls on a pending task while the hold and output registers are both full.
// Reset clears modes, counts, masks and pending bits at once; no clearing pass.
// A new input transaction is taken as soon as the sequencer is idle, even while
// the last result still sits in the output register.

module state_gated_periodic_task_timer_unit #(
	parameter int MAX_TASKS = 16,
	parameter int MAX_MODES = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [2:0]                        opcode,
	input  logic [sgtt_pkg::MODE_IN_W-1:0]    mode_index,
	input  logic [sgtt_pkg::KEY_W-1:0]        task_key,
	input  logic [sgtt_pkg::KEY_W-1:0]        period_ticks,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [sgtt_pkg::ST_W-1:0]         status,
	output logic [sgtt_pkg::SLOT_W-1:0]       slot,
	output logic [sgtt_pkg::KEY_W-1:0]        slot_key,
	output logic [sgtt_pkg::MODE_IN_W-1:0]    previous_mode,
	output logic                              mode_changed,
	output logic                              mode_match,
	output logic                              last
);
	import sgtt_pkg::*;

	localparam int CW  = $clog2(MAX_TASKS + 1);
	localparam int TW  = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int MCW = $clog2(MAX_MODES + 1);
	localparam int MW  = (MAX_MODES > 1) ? $clog2(MAX_MODES) : 1;

	localparam logic [CW-1:0]  TASK_FULL = CW'(MAX_TASKS);
	localparam logic [MCW-1:0] MODE_FULL = MCW'(MAX_MODES);
	localparam logic [RES_CNT_W-1:0] DRAIN_MAX = RES_CNT_W'(RESULT_LIMIT);

	// Sequencer states.
	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_EMIT   = 3'd1;
	localparam logic [2:0] S_REG    = 3'd2;
	localparam logic [2:0] S_REGSET = 3'd3;
	localparam logic [2:0] S_TICK   = 3'd4;
	localparam logic [2:0] S_DRAIN  = 3'd5;

	// Control state.
	logic [2:0]           state_q, state_d;
	logic [CW-1:0]        task_count_q, task_count_d;
	logic [MCW-1:0]       mode_count_q, mode_count_d;
	logic [MW-1:0]        cur_mode_q, cur_mode_d;
	logic                 out_valid_q, out_valid_d;
	logic                 hold_v_q, hold_v_d;
	logic                 found_q, found_d;
	logic [RES_CNT_W-1:0] n_q, n_d;

	// Payload registers.
	logic [KEY_W-1:0]     key_q;
	logic [KEY_W-1:0]     period_q;
	logic [MODE_IN_W-1:0] mode_q;
	logic [TW-1:0]        idx_q, idx_d;
	logic [TW-1:0]        hold_idx_q;
	logic [KEY_W-1:0]     hold_key_q;
	sgtt_res_t            res_q, res_d;
	sgtt_res_t            out_q, out_d;

	logic      accept;
	logic      out_free;
	logic      res_load;
	logic      out_load;
	logic      hold_load;
	logic      inject;
	logic      take_ok;
	logic      stall;
	sgtt_ctl_t ctl;
	logic [MW-1:0] sel_mode;

	// Chain wiring.
	logic [MAX_TASKS:0]   tok;
	sgtt_stat_t           stat [MAX_TASKS];
	logic [KEY_W-1:0]     key_vec [MAX_TASKS];
	logic [MAX_TASKS-1:0] pend_vec;
	logic [MAX_TASKS-1:0] valid_vec;

	logic             any_act;
	logic             pend_bus;
	logic             match_bus;
	logic [KEY_W-1:0] key_bus;
	logic [TW-1:0]    idx_bus;

	assign tok[0] = inject;

	for (genvar g = 0; g < MAX_TASKS; g++) begin : g_cell
		sgtt_cell #(
			.MAX_TASKS(MAX_TASKS),
			.MAX_MODES(MAX_MODES),
			.IDX      (g)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.tok_in  (tok[g]),
			.tok_out (tok[g+1]),
			.cnt     (task_count_q),
			.cur_mode(cur_mode_q),
			.sel_mode(sel_mode),
			.wr_idx  (idx_q),
			.key     (key_q),
			.period  (period_q),
			.stat    (stat[g]),
			.key_out (key_vec[g])
		);
		assign pend_vec[g]  = stat[g].pend;
		assign valid_vec[g] = stat[g].valid;
	end

	// Only the cell holding the token drives the shared result lines, so a
	// plain AND-OR selects its key and index.
	always_comb begin
		any_act   = 1'b0;
		pend_bus  = 1'b0;
		match_bus = 1'b0;
		key_bus   = '0;
		idx_bus   = '0;
		for (int i = 0; i < MAX_TASKS; i++) begin
			any_act   = any_act | stat[i].act;
			pend_bus  = pend_bus | (stat[i].act & stat[i].pend);
			match_bus = match_bus | (stat[i].act & stat[i].match);
			key_bus   = key_bus | ({KEY_W{stat[i].act}} & key_vec[i]);
			idx_bus   = idx_bus | ({TW{stat[i].act}} & TW'(i));
		end
	end

	assign in_ready = state_q == S_IDLE;
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// A pending task found during a drain is parked in the hold register until
	// the next one turns up, so that the final one can carry the last flag.
	assign take_ok = pend_bus && (n_q < DRAIN_MAX);
	assign stall   = take_ok && hold_v_q && !out_free;

	always_comb begin
		state_d      = state_q;
		task_count_d = task_count_q;
		mode_count_d = mode_count_q;
		cur_mode_d   = cur_mode_q;
		hold_v_d     = hold_v_q;
		found_d      = found_q;
		n_d          = n_q;
		idx_d        = idx_q;
		res_load     = 1'b0;
		res_d        = '0;
		res_d.last   = 1'b1;
		out_load     = 1'b0;
		out_d        = res_q;
		hold_load    = 1'b0;
		inject       = 1'b0;
		ctl          = '0;
		sel_mode     = MW'(mode_q);

		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (opcode)
						OP_ADD_MODE: begin
							if (mode_count_q >= MODE_FULL) begin
								res_d.status = ST_FULL;
							end else begin
								ctl.clr_mask = 1'b1;
								sel_mode     = MW'(mode_count_q);
								res_d.slot   = SLOT_W'(mode_count_q);
								mode_count_d = mode_count_q + MCW'(1);
							end
							res_load = 1'b1;
							state_d  = S_EMIT;
						end
						OP_SWITCH: begin
							if (32'(mode_index) < 32'(MAX_MODES)) begin
								cur_mode_d = MW'(mode_index);
							end
							res_d.slot    = SLOT_W'(cur_mode_d);
							res_d.prev    = MODE_IN_W'(cur_mode_q);
							res_d.changed = cur_mode_d != cur_mode_q;
							res_load      = 1'b1;
							state_d       = S_EMIT;
						end
						OP_QUERY: begin
							res_d.slot  = SLOT_W'(cur_mode_q);
							res_d.match = 32'(mode_index) == 32'(cur_mode_q);
							res_load    = 1'b1;
							state_d     = S_EMIT;
						end
						OP_REGISTER: begin
							if (task_count_q >= TASK_FULL) begin
								res_d.status = ST_FULL;
								res_load     = 1'b1;
								state_d      = S_EMIT;
							end else begin
								inject   = 1'b1;
								ctl.step = 1'b1;
								state_d  = S_REG;
							end
						end
						OP_TICK: begin
							inject   = 1'b1;
							ctl.step = 1'b1;
							state_d  = S_TICK;
						end
						OP_DRAIN: begin
							inject   = 1'b1;
							ctl.step = 1'b1;
							n_d      = '0;
							hold_v_d = 1'b0;
							state_d  = S_DRAIN;
						end
						default: begin
							res_load = 1'b1;
							state_d  = S_EMIT;
						end
					endcase
				end
			end
			S_EMIT: begin
				if (out_free) begin
					out_load = 1'b1;
					out_d    = res_q;
					state_d  = S_IDLE;
				end
			end
			S_REG: begin
				ctl.sweep = SW_SEARCH;
				if (!any_act) begin
					// No duplicate among the registered entries: a new one.
					ctl.clear = 1'b1;
					found_d   = 1'b0;
					idx_d     = TW'(task_count_q);
					state_d   = S_REGSET;
				end else if (match_bus) begin
					ctl.clear = 1'b1;
					found_d   = 1'b1;
					idx_d     = idx_bus;
					state_d   = S_REGSET;
				end else begin
					ctl.step = 1'b1;
				end
			end
			S_REGSET: begin
				ctl.wr_new   = !found_q;
				ctl.set_mask = 32'(mode_q) < 32'(MAX_MODES);
				if (!found_q) begin
					task_count_d = task_count_q + CW'(1);
				end
				res_d.slot = SLOT_W'(idx_q);
				res_load   = 1'b1;
				state_d    = S_EMIT;
			end
			S_TICK: begin
				ctl.sweep = SW_TICK;
				if (!any_act) begin
					ctl.clear = 1'b1;
					res_load  = 1'b1;
					state_d   = S_EMIT;
				end else begin
					ctl.step = 1'b1;
				end
			end
			S_DRAIN: begin
				ctl.sweep = SW_DRAIN;
				ctl.take  = take_ok;
				if (!any_act) begin
					ctl.clear = 1'b1;
					if (hold_v_q) begin
						res_d.slot = SLOT_W'(hold_idx_q);
						res_d.key  = hold_key_q;
					end else begin
						res_d.status = ST_EMPTY;
					end
					hold_v_d = 1'b0;
					res_load = 1'b1;
					state_d  = S_EMIT;
				end else if (!stall) begin
					ctl.step = 1'b1;
					if (take_ok) begin
						if (hold_v_q) begin
							out_load   = 1'b1;
							out_d      = '0;
							out_d.slot = SLOT_W'(hold_idx_q);
							out_d.key  = hold_key_q;
						end
						hold_load = 1'b1;
						hold_v_d  = 1'b1;
						n_d       = n_q + RES_CNT_W'(1);
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign out_valid_d = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			task_count_q <= '0;
			mode_count_q <= '0;
			cur_mode_q   <= '0;
			out_valid_q  <= 1'b0;
			hold_v_q     <= 1'b0;
			found_q      <= 1'b0;
			n_q          <= '0;
		end else begin
			state_q      <= state_d;
			task_count_q <= task_count_d;
			mode_count_q <= mode_count_d;
			cur_mode_q   <= cur_mode_d;
			out_valid_q  <= out_valid_d;
			hold_v_q     <= hold_v_d;
			found_q      <= found_d;
			n_q          <= n_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_q    <= task_key;
			period_q <= period_ticks;
			mode_q   <= mode_index;
		end
		idx_q <= idx_d;
		if (res_load) begin
			res_q <= res_d;
		end
		if (out_load) begin
			out_q <= out_d;
		end
		if (hold_load) begin
			hold_idx_q <= idx_bus;
			hold_key_q <= key_bus;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = out_q.status;
	assign slot          = out_q.slot;
	assign slot_key      = out_q.key;
	assign previous_mode = out_q.prev;
	assign mode_changed  = out_q.changed;
	assign mode_match    = out_q.match;
	assign last          = out_q.last;

	// The chain never carries more than one token.
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok[MAX_TASKS:1]))
		else $error("more than one token in the cell chain");

	// Every sweep clears its token before the sequencer goes idle.
	a_idle_no_token: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (tok[MAX_TASKS:1] == '0))
		else $error("token left in the chain while idle");

	// Only registered entries can ever be pending.
	a_pend_valid: assert property (@(posedge clk) disable iff (!arst_n)
		((pend_vec & ~valid_vec) == '0))
		else $error("pending bit set on an unregistered entry");

	// The drain hold register is used only inside a drain.
	a_hold_drain: assert property (@(posedge clk) disable iff (!arst_n)
		hold_v_q |-> (state_q == S_DRAIN))
		else $error("drain hold register valid outside a drain");

	// Counts never pass the table sizes.
	a_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(task_count_q <= TASK_FULL) && (mode_count_q <= MODE_FULL))
		else $error("task or mode count beyond table size");

endmodule

[hw/rtl/sgtt_cell.sv]
// One task entry of the timer chain: key, period, countdown, pending bit and
// its column of mode mask bits. Depends on sgtt_pkg.
`timescale 1ns / 1ps

module sgtt_cell #(
	parameter int MAX_TASKS = 16,
	parameter int MAX_MODES = 8,
	parameter int IDX       = 0
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  sgtt_pkg::sgtt_ctl_t                       ctl,
	input  logic                                      tok_in,
	output logic                                      tok_out,
	input  logic [$clog2(MAX_TASKS+1)-1:0]            cnt,
	input  logic [(MAX_MODES>1 ? $clog2(MAX_MODES) : 1)-1:0] cur_mode,
	input  logic [(MAX_MODES>1 ? $clog2(MAX_MODES) : 1)-1:0] sel_mode,
	input  logic [(MAX_TASKS>1 ? $clog2(MAX_TASKS) : 1)-1:0] wr_idx,
	input  logic [sgtt_pkg::KEY_W-1:0]                key,
	input  logic [sgtt_pkg::KEY_W-1:0]                period,
	output sgtt_pkg::sgtt_stat_t                      stat,
	output logic [sgtt_pkg::KEY_W-1:0]                key_out
);
	import sgtt_pkg::*;

	localparam int CW = $clog2(MAX_TASKS + 1);
	localparam int TW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

	logic                 tok_q;
	logic                 pend_q;
	logic [MAX_MODES-1:0] mask_q;
	logic [KEY_W-1:0]     key_q;
	logic [KEY_W-1:0]     reload_q;
	logic [KEY_W-1:0]     cnt_q;

	logic             valid;
	logic             act;
	logic             sel;
	logic             tick_go;
	logic             tick_hit;
	logic             drain_go;
	logic [KEY_W-1:0] dec;

	assign valid    = CW'(IDX) < cnt;
	assign act      = tok_q && valid;
	assign sel      = wr_idx == TW'(IDX);
	assign dec      = (cnt_q != '0) ? cnt_q - KEY_W'(1) : '0;
	assign tick_go  = ctl.step && act && (ctl.sweep == SW_TICK);
	assign tick_hit = mask_q[cur_mode] && (dec == '0);
	assign drain_go = ctl.step && act && (ctl.sweep == SW_DRAIN) && ctl.take && pend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q  <= 1'b0;
			pend_q <= 1'b0;
			mask_q <= '0;
		end else begin
			if (ctl.clear) begin
				tok_q <= 1'b0;
			end else if (ctl.step) begin
				tok_q <= tok_in;
			end
			if (tick_go && tick_hit) begin
				pend_q <= 1'b1;
			end else if (drain_go) begin
				pend_q <= 1'b0;
			end
			if (ctl.clr_mask) begin
				mask_q[sel_mode] <= 1'b0;
			end else if (ctl.set_mask && sel) begin
				mask_q[sel_mode] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.wr_new && sel) begin
			key_q    <= key;
			reload_q <= period;
			cnt_q    <= period;
		end else if (tick_go) begin
			cnt_q <= tick_hit ? reload_q : dec;
		end
	end

	assign tok_out    = tok_q;
	assign key_out    = key_q;
	assign stat.valid = valid;
	assign stat.act   = act;
	assign stat.pend  = pend_q;
	assign stat.match = (key_q == key) && (reload_q == period);

endmodule

[tb/testbench.sv]
// Self-checking testbench for state_gated_periodic_task_timer_unit.
// Depends on sgtt_pkg and the RTL of the block; it reads no files.
`timescale 1ns / 1ps

module testbench;

	import sgtt_pkg::*;

	// Table sizes that the block is built with; the predictor uses the same.
	localparam int MAX_TASKS    = 16;
	localparam int MAX_MODES    = 8;
	localparam int RANDOM_ITEMS = 136;
	// The receiver holds off this long once, so that the block backs up.
	localparam int LONG_HOLD    = 300;
	// Worst stretch with no transaction on either side is the long hold above;
	// a slow drain (16 results, each waiting out a receiver stall, plus the
	// chain walk) stays far below it. The limit is ten times that.
	localparam int IDLE_LIMIT   = 3000;
	// The tail outlasts the longest chain walk of the block.
	localparam int TAIL_CYCLES  = 40;

	// One row of the directed stimulus. When typed is set, the single result
	// of the row is written out by hand in want; otherwise the predictor decides.
	typedef struct {
		sgtt_op_t             op;
		logic [MODE_IN_W-1:0] mode;
		logic [KEY_W-1:0]     key;
		logic [KEY_W-1:0]     period;
		bit                   typed;
		sgtt_res_t            want;
	} cmd_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic [2:0]           opcode;
	logic [MODE_IN_W-1:0] mode_index;
	logic [KEY_W-1:0]     task_key;
	logic [KEY_W-1:0]     period_ticks;
	logic                 out_valid;
	logic                 out_ready;
	logic [ST_W-1:0]      status;
	logic [SLOT_W-1:0]    slot;
	logic [KEY_W-1:0]     slot_key;
	logic [MODE_IN_W-1:0] previous_mode;
	logic                 mode_changed;
	logic                 mode_match;
	logic                 last;

	// Predicted state of the timer table.
	logic [MODE_IN_W-1:0] cur_mode;
	int                   n_modes;
	int                   n_tasks;
	logic [KEY_W-1:0]     key_tab    [0:MAX_TASKS-1];
	logic [KEY_W-1:0]     period_tab [0:MAX_TASKS-1];
	logic [KEY_W-1:0]     count_tab  [0:MAX_TASKS-1];
	logic [MAX_TASKS-1:0] mode_mask  [0:MAX_MODES-1];
	logic [MAX_TASKS-1:0] pend_mask;

	// Results of the transaction just accepted, and all results still owed.
	sgtt_res_t fresh_results[$];
	sgtt_res_t awaited_results[$];
	cmd_row_t  directed_rows[$];

	int errors = 0;
	int idle_cycles = 0;
	bit hold_output = 1'b0;

	state_gated_periodic_task_timer_unit #(
		.MAX_TASKS(MAX_TASKS),
		.MAX_MODES(MAX_MODES)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.opcode       (opcode),
		.mode_index   (mode_index),
		.task_key     (task_key),
		.period_ticks (period_ticks),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.slot         (slot),
		.slot_key     (slot_key),
		.previous_mode(previous_mode),
		.mode_changed (mode_changed),
		.mode_match   (mode_match),
		.last         (last)
	);

	always #1 clk = ~clk;

	function automatic sgtt_res_t mk_res(logic [ST_W-1:0] st, logic [SLOT_W-1:0] idx,
			logic [KEY_W-1:0] k, logic [MODE_IN_W-1:0] prev, logic changed,
			logic match, logic fin);
		sgtt_res_t r;
		r.status  = st;
		r.slot    = idx;
		r.key     = k;
		r.prev    = prev;
		r.changed = changed;
		r.match   = match;
		r.last    = fin;
		return r;
	endfunction

	// Works out the results of one command and updates the predicted table.
	function automatic void predict_step(sgtt_op_t op, logic [MODE_IN_W-1:0] mode,
			logic [KEY_W-1:0] key, logic [KEY_W-1:0] period);
		logic [MODE_IN_W-1:0] prev;
		logic [MAX_TASKS-1:0] mask;
		sgtt_res_t            tail;
		int                   idx;
		int                   n;
		int                   i;
		case (op)
			OP_ADD_MODE: begin
				if (n_modes >= MAX_MODES) begin
					fresh_results.push_back(mk_res(ST_FULL, '0, '0, '0, 1'b0, 1'b0, 1'b1));
				end else begin
					mode_mask[n_modes] = '0;
					fresh_results.push_back(mk_res(ST_OK, SLOT_W'(n_modes), '0, '0,
						1'b0, 1'b0, 1'b1));
					n_modes++;
				end
			end
			OP_SWITCH: begin
				prev = cur_mode;
				if (int'(mode) < MAX_MODES)
					cur_mode = mode;
				fresh_results.push_back(mk_res(ST_OK, SLOT_W'(cur_mode), '0, prev,
					cur_mode != prev, 1'b0, 1'b1));
			end
			OP_QUERY: begin
				fresh_results.push_back(mk_res(ST_OK, SLOT_W'(cur_mode), '0, '0, 1'b0,
					mode == cur_mode, 1'b1));
			end
			OP_REGISTER: begin
				if (n_tasks >= MAX_TASKS) begin
					fresh_results.push_back(mk_res(ST_FULL, '0, '0, '0, 1'b0, 1'b0, 1'b1));
				end else begin
					// A matching key and period reuses the lowest such entry.
					idx = n_tasks;
					for (i = 0; i < n_tasks; i++)
						if (idx == n_tasks && key_tab[i] == key && period_tab[i] == period)
							idx = i;
					if (idx == n_tasks) begin
						key_tab[idx]    = key;
						period_tab[idx] = period;
						count_tab[idx]  = period;
						n_tasks++;
					end
					if (int'(mode) < MAX_MODES)
						mode_mask[mode][idx] = 1'b1;
					fresh_results.push_back(mk_res(ST_OK, SLOT_W'(idx), '0, '0,
						1'b0, 1'b0, 1'b1));
				end
			end
			OP_TICK: begin
				// Every timer counts down and stops at zero; only tasks in the
				// current mode turn pending and reload.
				mask = mode_mask[cur_mode];
				for (i = 0; i < n_tasks; i++) begin
					if (count_tab[i] != '0)
						count_tab[i] = count_tab[i] - 1'b1;
					if (mask[i] && count_tab[i] == '0) begin
						pend_mask[i] = 1'b1;
						count_tab[i] = period_tab[i];
					end
				end
				fresh_results.push_back(mk_res(ST_OK, '0, '0, '0, 1'b0, 1'b0, 1'b1));
			end
			OP_DRAIN: begin
				n = 0;
				for (i = 0; i < n_tasks && n < RESULT_LIMIT; i++) begin
					if (pend_mask[i]) begin
						pend_mask[i] = 1'b0;
						fresh_results.push_back(mk_res(ST_OK, SLOT_W'(i), key_tab[i], '0,
							1'b0, 1'b0, 1'b0));
						n++;
					end
				end
				if (n == 0) begin
					fresh_results.push_back(mk_res(ST_EMPTY, '0, '0, '0, 1'b0, 1'b0, 1'b1));
				end else begin
					tail = fresh_results.pop_back();
					tail.last = 1'b1;
					fresh_results.push_back(tail);
				end
			end
			default: begin
				fresh_results.push_back(mk_res(ST_OK, '0, '0, '0, 1'b0, 1'b0, 1'b1));
			end
		endcase
	endfunction

	function automatic void row_pred(sgtt_op_t op, logic [MODE_IN_W-1:0] mode,
			logic [KEY_W-1:0] key, logic [KEY_W-1:0] period);
		cmd_row_t r;
		r.op     = op;
		r.mode   = mode;
		r.key    = key;
		r.period = period;
		r.typed  = 1'b0;
		r.want   = '0;
		directed_rows.push_back(r);
	endfunction

	function automatic void row_typed(sgtt_op_t op, logic [MODE_IN_W-1:0] mode,
			logic [KEY_W-1:0] key, logic [KEY_W-1:0] period, logic [ST_W-1:0] st,
			logic [SLOT_W-1:0] idx, logic [MODE_IN_W-1:0] prev, logic changed,
			logic match);
		cmd_row_t r;
		r.op     = op;
		r.mode   = mode;
		r.key    = key;
		r.period = period;
		r.typed  = 1'b1;
		r.want   = mk_res(st, idx, '0, prev, changed, match, 1'b1);
		directed_rows.push_back(r);
	endfunction

	// Offers one command after gap idle cycles and holds it until it is
	// taken. Valid is not lowered here after the transaction: the next call,
	// made in the same time step, either replaces the payload or lowers it.
	task automatic send_item(sgtt_op_t op, logic [MODE_IN_W-1:0] mode,
			logic [KEY_W-1:0] key, logic [KEY_W-1:0] period, int gap, bit typed,
			sgtt_res_t want);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		opcode       <= op;
		mode_index   <= mode;
		task_key     <= key;
		period_ticks <= period;
		do @(posedge clk); while (!in_ready);
		predict_step(op, mode, key, period);
		if (typed)
			awaited_results.push_back(want);
		else
			foreach (fresh_results[i])
				awaited_results.push_back(fresh_results[i]);
		fresh_results.delete();
	endtask

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name,
				want, got);
			errors++;
		end
	endfunction

	// Every result transaction is compared with the oldest one still owed.
	always @(posedge clk) begin : result_monitor
		sgtt_res_t want;
		if (arst_n && out_valid && out_ready) begin
			if (awaited_results.size() == 0) begin
				$display("%0t ns: unexpected result, expected none, actual slot 0x%0h",
					$time, slot);
				errors++;
			end else begin
				want = awaited_results.pop_front();
				check_field("status", want.status, status);
				check_field("slot", want.slot, slot);
				check_field("slot_key", want.key, slot_key);
				check_field("previous_mode", want.prev, previous_mode);
				check_field("mode_changed", want.changed, mode_changed);
				check_field("mode_match", want.match, mode_match);
				check_field("last", want.last, last);
			end
		end
	end

	// The run is abandoned when no transaction moves on either channel for too long.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Result side: a random stall before each transaction, with
	// stretches of none, and one long hold-off when the sender asks for it.
	initial begin : result_receiver
		int stall;
		int taken;
		out_ready = 1'b0;
		taken = 0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_output) begin
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_output = 1'b0;
			end else begin
				stall = ((taken % 40) < 12) ? 0 : $urandom_range(0, 5);
				if (stall > 0) begin
					out_ready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			taken++;
		end
	end

	initial begin : command_sender
		sgtt_op_t             op;
		logic [MODE_IN_W-1:0] mode;
		logic [KEY_W-1:0]     key;
		logic [KEY_W-1:0]     period;
		int                   k;
		int                   pick;
		int                   gap;
		int                   j;

		arst_n       = 1'b0;
		in_valid     = 1'b0;
		opcode       = '0;
		mode_index   = '0;
		task_key     = '0;
		period_ticks = '0;

		cur_mode  = '0;
		n_modes   = 0;
		n_tasks   = 0;
		pend_mask = '0;
		for (j = 0; j < MAX_TASKS; j++) begin
			key_tab[j]    = '0;
			period_tab[j] = '0;
			count_tab[j]  = '0;
		end
		for (j = 0; j < MAX_MODES; j++)
			mode_mask[j] = '0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Fresh out of reset: current mode is 0, nothing is pending, the
		// table is empty and the two unused opcodes answer with all fields zero but last.
		row_typed(OP_QUERY, 3'd0, 16'h0000, 16'h0000, ST_OK, 4'd0, 3'd0, 1'b0, 1'b1);
		row_typed(OP_QUERY, 3'd7, 16'h0000, 16'h0000, ST_OK, 4'd0, 3'd0, 1'b0, 1'b0);
		row_typed(OP_DRAIN, 3'd0, 16'h0000, 16'h0000, ST_EMPTY, 4'd0, 3'd0, 1'b0, 1'b0);
		row_typed(OP_TICK, 3'd0, 16'h0000, 16'h0000, ST_OK, 4'd0, 3'd0, 1'b0, 1'b0);
		row_typed(OP_RSVD6, 3'd7, 16'hFFFF, 16'hFFFF, ST_OK, 4'd0, 3'd0, 1'b0, 1'b0);
		row_typed(OP_RSVD7, 3'd5, 16'hA5A5, 16'h5A5A, ST_OK, 4'd0, 3'd0, 1'b0, 1'b0);
		row_typed(OP_ADD_MODE, 3'd0, 16'h0000, 16'h0000, ST_OK, 4'd0, 3'd0, 1'b0, 1'b0);
		row_typed(OP_ADD_MODE, 3'd0, 16'h0000, 16'h0000, ST_OK, 4'd1, 3'd0, 1'b0, 1'b0);
		// A zero period task, an extreme period, a duplicate attached to the
		// top mode, and the same key with another period that gets a new entry.
		row_typed(OP_REGISTER, 3'd0, 16'hFFFF, 16'h0000, ST_OK, 4'd0, 3'd0, 1'b0, 1'b0);
		row_typed(OP_REGISTER, 3'd1, 16'h0000, 16'hFFFF, ST_OK, 4'd1, 3'd0, 1'b0, 1'b0);
		row_typed(OP_REGISTER, 3'd7, 16'hFFFF, 16'h0000, ST_OK, 4'd0, 3'd0, 1'b0, 1'b0);
		row_typed(OP_REGISTER, 3'd0, 16'hFFFF, 16'h0001, ST_OK, 4'd2, 3'd0, 1'b0, 1'b0);
		row_typed(OP_REGISTER, 3'd0, 16'h1234, 16'h0002, ST_OK, 4'd3, 3'd0, 1'b0, 1'b0);
		row_pred(OP_TICK, 3'd0, 16'h0000, 16'h0000);
		row_pred(OP_DRAIN, 3'd0, 16'h0000, 16'h0000);
		// Switching to the current mode again reports no change.
		row_typed(OP_SWITCH, 3'd7, 16'h0000, 16'h0000, ST_OK, 4'd7, 3'd0, 1'b1, 1'b0);
		row_typed(OP_SWITCH, 3'd7, 16'h0000, 16'h0000, ST_OK, 4'd7, 3'd7, 1'b0, 1'b0);
		row_typed(OP_QUERY, 3'd7, 16'h0000, 16'h0000, ST_OK, 4'd7, 3'd0, 1'b0, 1'b1);
		row_pred(OP_TICK, 3'd0, 16'h0000, 16'h0000);
		row_pred(OP_DRAIN, 3'd0, 16'h0000, 16'h0000);
		row_typed(OP_SWITCH, 3'd0, 16'h0000, 16'h0000, ST_OK, 4'd0, 3'd7, 1'b1, 1'b0);
		row_pred(OP_TICK, 3'd0, 16'h0000, 16'h0000);
		row_pred(OP_TICK, 3'd0, 16'h0000, 16'h0000);
		row_pred(OP_DRAIN, 3'd0, 16'h0000, 16'h0000);

		foreach (directed_rows[i])
			send_item(directed_rows[i].op, directed_rows[i].mode, directed_rows[i].key,
				directed_rows[i].period, $urandom_range(0, 5), directed_rows[i].typed,
				directed_rows[i].want);

		// Random part: mostly ticks and drains over a growing table, with mode
		// adds, switches and queries mixed in. Keys come from a small pool and
		// often repeat an existing entry, so duplicates are frequent; periods
		// are mostly short so that tasks fire. The table fills up along the way.
		for (k = 0; k < RANDOM_ITEMS; k++) begin
			if (k == 40)
				hold_output = 1'b1;
			if (k == 100) begin
				// Let the block run completely dry before going on.
				in_valid <= 1'b0;
				while (awaited_results.size() != 0) @(posedge clk);
			end
			pick = $urandom_range(0, 99);
			if (pick < 8)
				op = OP_ADD_MODE;
			else if (pick < 20)
				op = OP_SWITCH;
			else if (pick < 27)
				op = OP_QUERY;
			else if (pick < 45)
				op = OP_REGISTER;
			else if (pick < 75)
				op = OP_TICK;
			else if (pick < 95)
				op = OP_DRAIN;
			else if (pick < 97)
				op = OP_RSVD6;
			else
				op = OP_RSVD7;
			mode   = MODE_IN_W'($urandom_range(0, MAX_MODES - 1));
			key    = ($urandom_range(0, 3) == 0) ? KEY_W'($urandom)
				: KEY_W'($urandom_range(0, 15));
			period = ($urandom_range(0, 7) == 0) ? KEY_W'($urandom)
				: KEY_W'($urandom_range(0, 6));
			if (op == OP_REGISTER && n_tasks > 0 && $urandom_range(0, 3) == 0) begin
				j      = $urandom_range(0, n_tasks - 1);
				key    = key_tab[j];
				period = period_tab[j];
			end
			gap = ((k % 50) < 12) ? 0 : $urandom_range(0, 5);
			send_item(op, mode, key, period, gap, 1'b0, '0);
		end
		in_valid <= 1'b0;

		while (awaited_results.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0 && awaited_results.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

[files.f]
hw/rtl/sgtt_pkg.sv
hw/rtl/sgtt_cell.sv
hw/rtl/state_gated_periodic_task_timer_unit.sv
tb/testbench.sv
